// ----- rtl/core/ilt_pkg.sv -----
// Package for the indexed list table: field widths, command and status codes, sequencer states.
`timescale 1ns / 1ps
`default_nettype none
package ilt_pkg;

  localparam int unsigned CapacityDef = 128;
  localparam int unsigned CmdW        = 3;
  localparam int unsigned PosW        = 7;
  localparam int unsigned DataW       = 32;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountW      = 8;
  localparam int unsigned InDataW     = 48;
  localparam int unsigned OutDataW    = 56;
  localparam int unsigned InPadW      = InDataW - CmdW - PosW - DataW;
  localparam int unsigned OutPadW     = OutDataW - StatusW - DataW - PosW - CountW;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_FIND    = 3'd2,
    CMD_READ    = 3'd3,
    CMD_REPLACE = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_DELETE,
    S_FIND,
    S_READ,
    S_FINISH
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/core/indexed_list_table_top.sv -----
// Top level of the indexed list table: sequencer and entry store.
//
// An ordered list of signed 32-bit values in a store of CAPACITY entries.
// Commands arrive on the slave stream (s_axis_*), one per transaction:
// insert, delete, find, read or replace. Each command produces exactly one
// result on the master stream (m_axis_*) with a status and the entry count.
// Insert, delete and find each move or compare one entry per cycle through
// the single read and single write port of the store.
// One command is in work at a time; the next is taken once the current one
// has handed its result to the output register.
// Reset clears the entry count and the output valid; the store itself is
// not cleared, as only entries below the count are ever read.
// When the receiver stalls, the result holds in the output register while the
// next command is already accepted and executed; that command then waits for
// the register to drain before it completes.
`timescale 1ns / 1ps
`default_nettype none
module indexed_list_table_top #(
  parameter int unsigned CAPACITY = ilt_pkg::CapacityDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [2:0] cmd, [9:3] position, [41:10] value, [47:42] zero
  input  wire logic [ilt_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [1:0] status, [33:2] read_value, [40:34] found_position, [48:41] entry_count,
  // [55:49] zero
  output logic      [ilt_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [ilt_pkg::DataW-1:0] mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [ilt_pkg::DataW-1:0] mem_rdata;

  ilt_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ilt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

// ----- rtl/core/ilt_mem.sv -----
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ilt_mem #(
  parameter int unsigned DEPTH = ilt_pkg::CapacityDef,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [ilt_pkg::DataW-1:0] wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  output logic      [ilt_pkg::DataW-1:0] rdata_o
);

  logic [ilt_pkg::DataW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ilt_seq.sv -----
// Command sequencer: decodes commands, walks the store for shifts and searches, holds the result.
`timescale 1ns / 1ps
`default_nettype none
module ilt_seq #(
  parameter int unsigned CAPACITY = ilt_pkg::CapacityDef,
  parameter int unsigned AW       = $clog2(CAPACITY)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_tvalid_i,
  output logic                              s_tready_o,
  input  wire logic [ilt_pkg::InDataW-1:0]  s_tdata_i,
  output logic                              m_tvalid_o,
  input  wire logic                         m_tready_i,
  output logic      [ilt_pkg::OutDataW-1:0] m_tdata_o,
  output logic                              mem_we_o,
  output logic      [AW-1:0]                mem_waddr_o,
  output logic      [ilt_pkg::DataW-1:0]    mem_wdata_o,
  output logic                              mem_re_o,
  output logic      [AW-1:0]                mem_raddr_o,
  input  wire logic [ilt_pkg::DataW-1:0]    mem_rdata_i
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > ilt_pkg::PosW) ? CW : ilt_pkg::PosW;
  localparam int unsigned EXW  = (CW > ilt_pkg::CountW) ? CW : ilt_pkg::CountW;
  localparam logic [ilt_pkg::OutPadW-1:0] OutPadZero = '0;

  ilt_pkg::state_e state_q, state_d;
  ilt_pkg::cmd_e   cmd_in;
  logic [CMPW-1:0] pos_in;
  logic [ilt_pkg::DataW-1:0] val_in;

  logic [CMPW-1:0] pos_q, pos_d;
  logic [ilt_pkg::DataW-1:0] val_q, val_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   wa_q, wa_d;
  logic            pend_q, pend_d;
  ilt_pkg::status_e res_st_q, res_st_d;
  logic [ilt_pkg::DataW-1:0] res_rv_q, res_rv_d;
  logic [AW-1:0]   res_fp_q, res_fp_d;
  logic            m_valid_q, m_valid_d;
  logic [ilt_pkg::OutDataW-1:0] m_data_q, m_data_d;

  logic [CMPW-1:0] count_x, idx_x;
  logic [CW-1:0]   idx_dec;
  logic [CMPW-1:0] fp_x;
  logic [EXW-1:0]  cnt_out;
  logic            accept;

  assign cmd_in  = ilt_pkg::cmd_e'(s_tdata_i[ilt_pkg::CmdW-1:0]);
  assign pos_in  = CMPW'(s_tdata_i[ilt_pkg::CmdW +: ilt_pkg::PosW]);
  assign val_in  = s_tdata_i[ilt_pkg::CmdW + ilt_pkg::PosW +: ilt_pkg::DataW];
  assign count_x = CMPW'(count_q);
  assign idx_x   = CMPW'(idx_q);
  assign idx_dec = idx_q - CW'(1);
  assign fp_x    = CMPW'(res_fp_q);
  assign cnt_out = EXW'(count_q);

  assign s_tready_o = (state_q == ilt_pkg::S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ilt_pkg::S_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    wa_q     <= wa_d;
    res_st_q <= res_st_d;
    res_rv_q <= res_rv_d;
    res_fp_q <= res_fp_d;
    m_data_q <= m_data_d;
  end

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    val_d     = val_q;
    count_d   = count_q;
    idx_d     = idx_q;
    wa_d      = wa_q;
    pend_d    = 1'b0;
    res_st_d  = res_st_q;
    res_rv_d  = res_rv_q;
    res_fp_d  = res_fp_q;
    m_valid_d = m_valid_q && !m_tready_i;
    m_data_d  = m_data_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wa_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AW-1:0];

    unique case (state_q)
      ilt_pkg::S_IDLE: begin
        if (accept) begin
          pos_d    = pos_in;
          val_d    = val_in;
          res_st_d = ilt_pkg::ST_OK;
          res_rv_d = '0;
          res_fp_d = '0;
          state_d  = ilt_pkg::S_FINISH;
          unique case (cmd_in)
            ilt_pkg::CMD_INSERT: begin
              if (pos_in > count_x) begin
                res_st_d = ilt_pkg::ST_RANGE;
              end else if (count_q >= CW'(CAPACITY)) begin
                res_st_d = ilt_pkg::ST_FULL;
              end else begin
                idx_d   = count_q;
                state_d = ilt_pkg::S_INSERT;
              end
            end
            ilt_pkg::CMD_DELETE: begin
              if (pos_in >= count_x) begin
                res_st_d = ilt_pkg::ST_RANGE;
              end else begin
                idx_d   = CW'(pos_in) + CW'(1);
                state_d = ilt_pkg::S_DELETE;
              end
            end
            ilt_pkg::CMD_FIND: begin
              idx_d   = '0;
              state_d = ilt_pkg::S_FIND;
            end
            ilt_pkg::CMD_READ: begin
              if (pos_in >= count_x) begin
                res_st_d = ilt_pkg::ST_RANGE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = pos_in[AW-1:0];
                state_d     = ilt_pkg::S_READ;
              end
            end
            ilt_pkg::CMD_REPLACE: begin
              if (pos_in >= count_x) begin
                res_st_d = ilt_pkg::ST_RANGE;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = pos_in[AW-1:0];
                mem_wdata_o = val_in;
              end
            end
            default: begin
              res_st_d = ilt_pkg::ST_RANGE;
            end
          endcase
        end
      end

      ilt_pkg::S_INSERT: begin
        // Move entries up from the top; the last read lands one slot higher.
        mem_we_o = pend_q;
        if (idx_x > pos_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_dec[AW-1:0];
          wa_d        = idx_q[AW-1:0];
          idx_d       = idx_dec;
          pend_d      = 1'b1;
        end else if (!pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pos_q[AW-1:0];
          mem_wdata_o = val_q;
          count_d     = count_q + CW'(1);
          state_d     = ilt_pkg::S_FINISH;
        end
      end

      ilt_pkg::S_DELETE: begin
        mem_we_o = pend_q;
        if (idx_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q[AW-1:0];
          wa_d        = idx_dec[AW-1:0];
          idx_d       = idx_q + CW'(1);
          pend_d      = 1'b1;
        end else if (!pend_q) begin
          count_d = count_q - CW'(1);
          state_d = ilt_pkg::S_FINISH;
        end
      end

      ilt_pkg::S_FIND: begin
        // Check the entry read last cycle before scanning further.
        if (pend_q && (mem_rdata_i == val_q)) begin
          res_fp_d = wa_q;
          state_d  = ilt_pkg::S_FINISH;
        end else if (idx_q < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q[AW-1:0];
          wa_d        = idx_q[AW-1:0];
          idx_d       = idx_q + CW'(1);
          pend_d      = 1'b1;
        end else begin
          res_st_d = ilt_pkg::ST_MISSING;
          state_d  = ilt_pkg::S_FINISH;
        end
      end

      ilt_pkg::S_READ: begin
        res_rv_d = mem_rdata_i;
        state_d  = ilt_pkg::S_FINISH;
      end

      ilt_pkg::S_FINISH: begin
        if (!m_valid_q || m_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {OutPadZero, cnt_out[ilt_pkg::CountW-1:0], fp_x[ilt_pkg::PosW-1:0],
                       res_rv_q, res_st_q};
          state_d   = ilt_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ilt_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
